@@ sv/lpht_pkg.sv @@
// Types and codes shared by the linear-probe hash table and its checker.
// No dependencies.
package lpht_pkg;

    typedef enum logic [2:0] {
        STAT_STORED  = 3'd0,
        STAT_DUP     = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_FOUND   = 3'd3,
        STAT_MISSING = 3'd4,
        STAT_EMPTY   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_PROBE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic        action;
        logic [63:0] key_first_bytes;
        logic [7:0]  key_ninth_byte;
        logic [3:0]  key_length;
    } lpht_in_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] slot;
    } lpht_out_t;

    typedef struct packed {
        logic        occupied;
        logic [7:0]  high_byte;
        logic [63:0] low_bytes;
    } lpht_entry_t;

endpackage

@@ sv/linear_probe_hash_table_top.sv @@
// Linear-probe hash table of short byte keys, insert and search.
// Depends on lpht_pkg.
//
//   channel  ports                       beat
//   input    s_valid s_ready s_data      lpht_in_t  (action, key, length)
//   result   m_valid m_ready m_data      lpht_out_t (status, slot)
//
// After reset the store is cleared one slot a cycle, with s_ready low.
// An item is accepted in S_IDLE; S_HASH then does the reciprocal multiply for the modulo of
// the byte sum, and S_MOD multiplies back and subtracts. S_PROBE reads one probed slot a cycle
// (the single memory read port), up to TABLE_SLOTS slots, and S_FINISH hands the result over.
// An empty key goes from S_IDLE straight to S_FINISH.
// A result waiting on m_ready does not block the next accept; it blocks only the hand-over
// of the following result.
module linear_probe_hash_table_top #(
    parameter int TABLE_SLOTS = 13,
    parameter int KEY_BYTES   = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lpht_pkg::lpht_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lpht_pkg::lpht_out_t m_data
);
    import lpht_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int SUM_W   = $clog2(KEY_BYTES * 255 + 1);
    localparam int SHIFT   = SUM_W + IDX_W;
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int SLOT_W  = (IDX_W > 4) ? IDX_W : 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** SHIFT + TABLE_SLOTS - 1) / TABLE_SLOTS);

    lpht_entry_t mem [TABLE_SLOTS];
    lpht_entry_t rd_q;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  probes_reg, probes_next;
    logic [SUM_W-1:0]  quot_reg, quot_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              search_reg, search_next;
    logic [63:0]       lo_reg, lo_next;
    logic [7:0]        hi_reg, hi_next;
    lpht_out_t         res_reg, res_next;
    lpht_out_t         out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    lpht_entry_t       wr_data;

    logic [7:0]        key_byte [9];
    logic [3:0]        len_sat;
    logic              run;
    logic [63:0]       key_lo;
    logic [7:0]        key_hi;
    logic [SUM_W-1:0]  key_sum;
    logic              key_empty;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  mod_sub;
    logic [IDX_W-1:0]  home_idx;
    logic [SLOT_W-1:0] slot_ext;
    logic              hit;

    // key masking and byte sum
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            key_byte[b] = s_data.key_first_bytes[8*b +: 8];
        end
        key_byte[8] = s_data.key_ninth_byte;
        len_sat = (s_data.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : s_data.key_length;
        run = 1'b1;
        key_lo = '0;
        key_hi = '0;
        key_sum = '0;
        for (int b = 0; b < 9; b++) begin
            run = run && (4'(b) < len_sat) && (key_byte[b] != 8'd0);
            if (run) begin
                if (b < 8) begin
                    key_lo[8*b +: 8] = key_byte[b];
                end else begin
                    key_hi = key_byte[b];
                end
                key_sum = key_sum + SUM_W'(key_byte[b]);
            end
        end
        key_empty = (len_sat == 4'd0) || (key_byte[0] == 8'd0);
    end

    assign prod     = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign mod_sub  = sum_reg - SUM_W'(quot_reg * SUM_W'(TABLE_SLOTS));
    assign home_idx = IDX_W'(mod_sub);
    assign slot_ext = SLOT_W'(idx_reg);
    assign hit      = (rd_q.low_bytes == lo_reg) && (rd_q.high_byte == hi_reg);

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        idx_next     = idx_reg;
        probes_next  = probes_reg;
        quot_next    = quot_reg;
        sum_next     = sum_reg;
        search_next  = search_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = '{occupied: 1'b1, high_byte: hi_reg, low_bytes: lo_reg};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    search_next = s_data.action;
                    lo_next     = key_lo;
                    hi_next     = key_hi;
                    sum_next    = key_sum;
                    if (key_empty) begin
                        res_next   = '{status: STAT_EMPTY, slot: 4'd0};
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                quot_next  = SUM_W'(prod >> SHIFT);
                state_next = S_MOD;
            end
            S_MOD: begin
                idx_next    = home_idx;
                probes_next = '0;
                state_next  = S_PROBE;
            end
            S_PROBE: begin
                if (!rd_q.occupied) begin
                    if (search_reg) begin
                        res_next = '{status: STAT_MISSING, slot: 4'd0};
                    end else begin
                        wr_en    = 1'b1;
                        res_next = '{status: STAT_STORED, slot: slot_ext[3:0]};
                    end
                    state_next = S_FINISH;
                end else if (hit) begin
                    if (search_reg) begin
                        res_next = '{status: STAT_FOUND, slot: slot_ext[3:0]};
                    end else begin
                        res_next = '{status: STAT_DUP, slot: 4'd0};
                    end
                    state_next = S_FINISH;
                end else if (probes_reg == LAST_IDX) begin
                    res_next   = '{status: search_reg ? STAT_MISSING : STAT_FULL, slot: 4'd0};
                    state_next = S_FINISH;
                end else begin
                    probes_next = probes_reg + 1'b1;
                    idx_next    = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        probes_reg <= probes_next;
        quot_reg   <= quot_next;
        sum_reg    <= sum_next;
        search_reg <= search_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[idx_next];
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ sv/lpht_checker.sv @@
// Port-level checks for linear_probe_hash_table_top, and the bind that attaches them.
// Depends on lpht_pkg and linear_probe_hash_table_top.
module lpht_checker #(
    parameter int TABLE_SLOTS = 13
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lpht_pkg::lpht_out_t m_data
);
    import lpht_pkg::*;

    logic slot_in_range;
    assign slot_in_range = (TABLE_SLOTS > 16) || (32'(m_data.slot) < 32'(TABLE_SLOTS));

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("handshake active right after reset");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_DUP || m_data.status == STAT_FULL ||
                    m_data.status == STAT_MISSING || m_data.status == STAT_EMPTY)
        |-> m_data.slot == 4'd0)
        else $error("nonzero slot on a result without a slot");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_STORED || m_data.status == STAT_FOUND)
        |-> slot_in_range)
        else $error("slot beyond the table");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat accepted while an item is in work");

endmodule

bind linear_probe_hash_table_top lpht_checker #(.TABLE_SLOTS(TABLE_SLOTS)) u_lpht_checker (.*);

@@ tb/sv/tb_linear_probe_hash_table_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_hash_table_top: a directed
// insert/search sequence, then random traffic. Results are compared with a
// local model of the hash table. Depends on lpht_pkg and the top-level RTL.
module tb_linear_probe_hash_table_top;
    import lpht_pkg::*;

    localparam int TABLE_SLOTS = 13;
    localparam int KEY_BYTES = 9;
    localparam int RANDOM_ITEMS = 2000;
    localparam int POOL_KEYS = 24;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    lpht_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lpht_out_t m_data;

    lpht_in_t pending_items[$];
    lpht_out_t expected_results[$];
    logic [71:0] slot_key[TABLE_SLOTS] = '{default: '0};
    bit slot_used[TABLE_SLOTS] = '{default: 1'b0};
    logic [71:0] key_pool[POOL_KEYS];
    int key_pool_len[POOL_KEYS];

    int tx_idle_pct = 35;
    int rx_idle_pct = 49;
    int items_accepted = 0;
    int results_checked = 0;
    int error_count = 0;
    int stall_cycles = 0;
    int status_seen[6] = '{default: 0};
    logic in_taken = 1'b0;

    always #2 aclk = ~aclk;

    linear_probe_hash_table_top #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .KEY_BYTES  (KEY_BYTES)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic lpht_out_t predict_lookup(lpht_in_t item);
        logic [71:0] key;
        int key_len;
        int eff;
        int sum;
        int idx;
        bit done;
        lpht_out_t res;
        key = {item.key_ninth_byte, item.key_first_bytes};
        key_len = (item.key_length > KEY_BYTES) ? KEY_BYTES : int'(item.key_length);
        eff = 0;
        while (eff < key_len && key[8*eff +: 8] != 8'd0) eff++;
        sum = 0;
        for (int b = 0; b < 9; b++) begin
            if (b >= eff) key[8*b +: 8] = 8'd0;
            sum += key[8*b +: 8];
        end
        res.status = STAT_EMPTY;
        res.slot = '0;
        if (eff == 0) return res;
        idx = sum % TABLE_SLOTS;
        res.status = (item.action == ACT_SEARCH) ? STAT_MISSING : STAT_FULL;
        done = 1'b0;
        for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
            if (!slot_used[idx]) begin
                if (item.action == ACT_INSERT) begin
                    slot_key[idx] = key;
                    slot_used[idx] = 1'b1;
                    res.status = STAT_STORED;
                    res.slot = idx[3:0];
                end else begin
                    res.status = STAT_MISSING;
                end
                done = 1'b1;
            end else if (slot_key[idx] == key) begin
                if (item.action == ACT_SEARCH) begin
                    res.status = STAT_FOUND;
                    res.slot = idx[3:0];
                end else begin
                    res.status = STAT_DUP;
                end
                done = 1'b1;
            end else begin
                idx = (idx + 1) % TABLE_SLOTS;
            end
        end
        return res;
    endfunction

    function automatic logic [71:0] random_bytes();
        return {8'($urandom_range(0, 255)), $urandom, $urandom};
    endfunction

    task automatic push_item(logic act, logic [71:0] key, int key_len);
        lpht_in_t item;
        item.action = act;
        item.key_first_bytes = key[63:0];
        item.key_ninth_byte = key[71:64];
        item.key_length = key_len[3:0];
        pending_items.push_back(item);
    endtask

    // Pool key with fresh tail bytes; a zero byte ends a key shorter than KEY_BYTES for any length.
    task automatic push_pool_item();
        int p;
        int key_len;
        logic [71:0] key;
        p = $urandom_range(0, POOL_KEYS - 1);
        key_len = key_pool_len[p];
        key = random_bytes();
        for (int b = 0; b < key_len; b++) key[8*b +: 8] = key_pool[p][8*b +: 8];
        if (key_len < KEY_BYTES) begin
            key[8*key_len +: 8] = 8'd0;
            push_item(1'($urandom_range(0, 1)), key, $urandom_range(key_len, 15));
        end else begin
            push_item(1'($urandom_range(0, 1)), key, $urandom_range(KEY_BYTES, 15));
        end
    endtask

    // Sample accepted beats, predict their results and check the results that come out.
    always @(posedge aclk) begin
        lpht_out_t want;
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(predict_lookup(s_data));
            items_accepted++;
        end
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d slot %0d",
                                          m_data.status, m_data.slot));
            end else begin
                want = expected_results.pop_front();
                status_seen[want.status]++;
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              results_checked, m_data.status, want.status));
                if (m_data.slot !== want.slot)
                    report_mismatch($sformatf("result %0d slot %0d, want %0d",
                                              results_checked, m_data.slot, want.slot));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Drive the input channel and the result ready at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial begin
        int total;
        int r;
        int key_len;
        logic [71:0] key;

        for (int p = 0; p < POOL_KEYS; p++) begin
            key_pool_len[p] = $urandom_range(1, KEY_BYTES);
            for (int b = 0; b < 9; b++) key_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
        end

        push_item(ACT_INSERT, 72'h4241, 0);
        push_item(ACT_INSERT, 72'h42_4100, 5);
        push_item(ACT_SEARCH, 72'h41, 1);
        push_item(ACT_INSERT, 72'h41, 1);
        push_item(ACT_INSERT, 72'h41, 1);
        push_item(ACT_SEARCH, 72'h41, 1);
        push_item(ACT_INSERT, 72'h4E, 1);
        push_item(ACT_INSERT, 72'h4D, 1);
        push_item(ACT_INSERT, 72'h5A, 1);
        push_item(ACT_SEARCH, 72'h5A, 1);
        push_item(ACT_INSERT, {9{8'hFF}}, 15);
        push_item(ACT_SEARCH, {9{8'hFF}}, 9);
        push_item(ACT_SEARCH, 72'hFF_FFFF_FFFF_55AA_0041, 9);
        push_item(ACT_SEARCH, 72'h7F_FFFF_FFFF_FFFF_FFFF, 8);
        for (int c = 8'h61; c <= 8'h6A; c++) push_item(ACT_INSERT, 72'(c), 1);
        push_item(ACT_SEARCH, 72'h30, 1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                push_pool_item();
            end else if (r < 90) begin
                push_item(1'($urandom_range(0, 1)), random_bytes(), $urandom_range(0, 15));
            end else begin
                key = random_bytes();
                key_len = $urandom_range(0, 15);
                if (r < 95) key_len = 0;
                else key[7:0] = 8'd0;
                push_item(1'($urandom_range(0, 1)), key, key_len);
            end
        end
        total = pending_items.size();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (items_accepted >= total / 3);
        tx_idle_pct = 49;
        rx_idle_pct = 35;
        wait (items_accepted >= 2 * total / 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        wait (pending_items.size() == 0 && !s_valid && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d insert/search beats, checked %0d results.",
                 items_accepted, results_checked);
        $display("Stored %0d, duplicate %0d, full %0d, found %0d, not found %0d, empty %0d.",
                 status_seen[STAT_STORED], status_seen[STAT_DUP], status_seen[STAT_FULL],
                 status_seen[STAT_FOUND], status_seen[STAT_MISSING], status_seen[STAT_EMPTY]);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
